@@ hw/rtl/rsof_pkg.sv @@
`timescale 1ns / 1ps

package rsof_pkg;

   // sample width default and fixed register widths
   localparam int SAMPLE_BITS_DEF = 13;
   localparam int CFG_BITS        = 13;
   localparam int MODE_BITS       = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int VEL_BITS        = 15;
   localparam int VEL_MIN         = -16384;
   localparam int VEL_MAX         = 16383;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CLAMP  = 2'd0,
      MODE_EXTRAP = 2'd1,
      MODE_HOLD   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_BELOW = 2'd1,
      ERR_ABOVE = 2'd2,
      ERR_JUMP  = 2'd3
   } err_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE     = 2'd0,
      CSR_MIN_DIST = 2'd1,
      CSR_MAX_DIST = 2'd2,
      CSR_MAX_JUMP = 2'd3
   } csr_index_type;

   localparam logic [MODE_BITS-1:0] MODE_RESET     = MODE_HOLD;
   localparam logic [CFG_BITS-1:0]  MIN_DIST_RESET = 13'd80;
   localparam logic [CFG_BITS-1:0]  MAX_DIST_RESET = 13'd4000;
   localparam logic [CFG_BITS-1:0]  MAX_JUMP_RESET = 13'd480;

endpackage

@@ hw/rtl/rsof_core.sv @@
`timescale 1ns / 1ps

module rsof_core import rsof_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0] raw,
   input  logic [SAMPLE_BITS-1:0] last,
   input  logic [SAMPLE_BITS-1:0] older,
   input  logic [MODE_BITS-1:0]   mode,
   input  logic [CFG_BITS-1:0]    min_dist,
   input  logic [CFG_BITS-1:0]    max_dist,
   input  logic [CFG_BITS-1:0]    max_jump,
   output logic [SAMPLE_BITS-1:0] corr,
   output logic [VEL_BITS-1:0]    vel,
   output err_type                err,
   output logic                   fixed
);

   // signed working width with headroom for 2*last and 2*diff
   localparam int CW = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 3;
   localparam logic signed [CW-1:0] VMIN = CW'(VEL_MIN);
   localparam logic signed [CW-1:0] VMAX = CW'(VEL_MAX);

   logic signed [CW-1:0] raw_s, last_s, older_s, min_s, max_s, jump_s, smax_s;
   logic signed [CW-1:0] diff_s, adiff_s, extrap_s, pick_s, res_s, vdiff_s, vsat_s;
   logic                 below, above, jump;

   assign raw_s   = signed'({{(CW-SAMPLE_BITS){1'b0}}, raw});
   assign last_s  = signed'({{(CW-SAMPLE_BITS){1'b0}}, last});
   assign older_s = signed'({{(CW-SAMPLE_BITS){1'b0}}, older});
   assign min_s   = signed'({{(CW-CFG_BITS){1'b0}}, min_dist});
   assign max_s   = signed'({{(CW-CFG_BITS){1'b0}}, max_dist});
   assign jump_s  = signed'({{(CW-CFG_BITS){1'b0}}, max_jump});
   assign smax_s  = signed'({{(CW-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}});

   assign diff_s   = raw_s - last_s;
   assign adiff_s  = diff_s[CW-1] ? -diff_s : diff_s;
   assign below    = raw_s < min_s;
   assign above    = raw_s > max_s;
   assign jump     = adiff_s > jump_s;
   assign extrap_s = (last_s <<< 1) - older_s;

   always_comb begin
      pick_s = raw_s;
      err    = ERR_NONE;
      fixed  = 1'b0;
      unique case (mode)
         MODE_CLAMP: begin
            if (below) begin
               err = ERR_BELOW; pick_s = min_s; fixed = 1'b1;
            end else if (above) begin
               err = ERR_ABOVE; pick_s = max_s; fixed = 1'b1;
            end
         end
         MODE_EXTRAP: begin
            if (jump) begin
               err = ERR_JUMP; pick_s = extrap_s; fixed = 1'b1;
            end
         end
         MODE_HOLD: begin
            if (below)      err = ERR_BELOW;
            else if (above) err = ERR_ABOVE;
            else if (jump)  err = ERR_JUMP;
            if (below || above || jump) begin
               pick_s = last_s; fixed = 1'b1;
            end
         end
         default: begin
            // unused mode: sample passes unchanged
            pick_s = raw_s;
         end
      endcase
   end

   // saturate to the sample range
   always_comb begin
      if (pick_s < 0)           res_s = '0;
      else if (pick_s > smax_s) res_s = smax_s;
      else                      res_s = pick_s;
   end

   assign vdiff_s = (res_s - last_s) <<< 1;

   always_comb begin
      if (vdiff_s < VMIN)      vsat_s = VMIN;
      else if (vdiff_s > VMAX) vsat_s = VMAX;
      else                     vsat_s = vdiff_s;
   end

   assign corr = res_s[SAMPLE_BITS-1:0];
   assign vel  = vsat_s[VEL_BITS-1:0];

endmodule

@@ hw/rtl/range_sample_outlier_filter.sv @@
`timescale 1ns / 1ps

// range sample outlier filter
// req channel: one raw distance word (1/16 cm) per handshake, taken when
// req_valid is high and req_stall is low. rsp channel: one word per input
// with corrected distance, velocity, error code and a corrected flag, taken
// when rsp_valid is high and rsp_stall is low.
// csr port: write csr_wdata to register csr_index when csr_write is high
// (0 mode, 1 min distance, 2 max distance, 3 max jump); write only while idle.
// data path: a word accepted into the input register passes through the core
// and is written to the result register that drives rsp.
// throughput: one word per cycle while rsp_stall is low; the only loop is
// the two-sample history, which is updated in the same cycle the word moves
// from the input register to the result register.
// rsp_stall holds the result register; the input register still takes one
// more word, then req_stall rises until the result is taken.
// reset: both channels empty, history cleared to zero, registers back to
// hold mode, window 80..4000, max jump 480.
module range_sample_outlier_filter import rsof_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_raw_distance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_corrected_distance,
   output logic signed [VEL_BITS-1:0] rsp_velocity,
   output logic [1:0]                rsp_error_code,
   output logic                      rsp_corrected,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [CFG_BITS-1:0]    min_ff, min_in, max_ff, max_in, jump_ff, jump_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_raw_ff, in_raw_in;
   logic [SAMPLE_BITS-1:0] last_ff, last_in, older_ff, older_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_corr_ff, out_corr_in;
   logic [VEL_BITS-1:0]    out_vel_ff, out_vel_in;
   err_type                out_err_ff, out_err_in;
   logic                   out_fixed_ff, out_fixed_in;

   logic [SAMPLE_BITS-1:0] core_corr;
   logic [VEL_BITS-1:0]    core_vel;
   err_type                core_err;
   logic                   core_fixed;
   logic                   out_load, in_load;

   rsof_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
      .raw      (in_raw_ff),
      .last     (last_ff),
      .older    (older_ff),
      .mode     (mode_ff),
      .min_dist (min_ff),
      .max_dist (max_ff),
      .max_jump (jump_ff),
      .corr     (core_corr),
      .vel      (core_vel),
      .err      (core_err),
      .fixed    (core_fixed)
   );

   // result register frees when empty or taken this cycle
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      mode_in = mode_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      jump_in = jump_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:     mode_in = csr_wdata[MODE_BITS-1:0];
            CSR_MIN_DIST: min_in  = csr_wdata;
            CSR_MAX_DIST: max_in  = csr_wdata;
            CSR_MAX_JUMP: jump_in = csr_wdata;
            default:      mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_raw_in   = in_raw_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
         in_raw_in   = req_raw_distance;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_corr_in  = out_corr_ff;
      out_vel_in   = out_vel_ff;
      out_err_in   = out_err_ff;
      out_fixed_in = out_fixed_ff;
      last_in      = last_ff;
      older_in     = older_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_corr_in  = core_corr;
         out_vel_in   = core_vel;
         out_err_in   = core_err;
         out_fixed_in = core_fixed;
         older_in     = last_ff;
         last_in      = core_corr;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         min_ff       <= MIN_DIST_RESET;
         max_ff       <= MAX_DIST_RESET;
         jump_ff      <= MAX_JUMP_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_ff      <= '0;
         older_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         jump_ff      <= jump_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
         older_ff     <= older_in;
      end
   end

   always_ff @(posedge clock) begin
      in_raw_ff    <= in_raw_in;
      out_corr_ff  <= out_corr_in;
      out_vel_ff   <= out_vel_in;
      out_err_ff   <= out_err_in;
      out_fixed_ff <= out_fixed_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_corrected_distance = out_corr_ff;
   assign rsp_velocity           = signed'(out_vel_ff);
   assign rsp_error_code         = out_err_ff;
   assign rsp_corrected          = out_fixed_ff;

endmodule
